>>> src/hesc_pkg.sv
// ---------------------------------------------------------------------------
// hesc_pkg
// Shared widths, types, constants and the arctangent table of the
// heading-error step cost core.
// ---------------------------------------------------------------------------
package hesc_pkg;

    localparam int POS_W         = 24;
    localparam int YAW_W         = 20;
    localparam int WEIGHT_W      = 16;
    localparam int COST_W        = 26;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 24;

    localparam int DIFF_W        = POS_W + 1;
    localparam int SQ_W          = 2 * DIFF_W - 1;
    localparam int SUM_W         = SQ_W + 1;
    localparam int LIM_W         = 2 * POS_W;
    localparam int PRESCALE      = 24;
    localparam int CW            = 52;
    localparam int Z_W           = 20;
    localparam int D_W           = 22;
    localparam int MOD_W         = 19;
    localparam int ERR_W         = 18;
    localparam int PROD_W        = ERR_W + WEIGHT_W;
    localparam int WEIGHT_FRAC   = 8;

    localparam int CORDIC_STAGES = 16;
    localparam int IDX_W         = 5;

    localparam int ANG_PI        = 205887;
    localparam int ANG_HALF_PI   = 102944;
    localparam int ANG_TWO_PI    = 411775;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X     = 2'd0,
        REG_GOAL_Y     = 2'd1,
        REG_DISABLE    = 2'd2,
        REG_WEIGHT     = 2'd3
    } hesc_reg_t;

    typedef struct packed {
        logic signed [YAW_W-1:0] yaw;
        logic                    near;
        logic                    zero;
    } hesc_side_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [IDX_W-1:0] idx);
        logic signed [Z_W-1:0] a;
        case (idx)
            5'd0:    a = Z_W'(51472);
            5'd1:    a = Z_W'(30385);
            5'd2:    a = Z_W'(16055);
            5'd3:    a = Z_W'(8150);
            5'd4:    a = Z_W'(4091);
            5'd5:    a = Z_W'(2047);
            5'd6:    a = Z_W'(1024);
            5'd7:    a = Z_W'(512);
            5'd8:    a = Z_W'(256);
            5'd9:    a = Z_W'(128);
            5'd10:   a = Z_W'(64);
            5'd11:   a = Z_W'(32);
            5'd12:   a = Z_W'(16);
            5'd13:   a = Z_W'(8);
            5'd14:   a = Z_W'(4);
            5'd15:   a = Z_W'(2);
            5'd16:   a = Z_W'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> src/hesc_if.sv
// ---------------------------------------------------------------------------
// hesc_if
// Valid/ready channels carrying one step item in and one cost item out.
// ---------------------------------------------------------------------------
interface hesc_in_if import hesc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] from_x;
    logic signed [POS_W-1:0] from_y;
    logic signed [YAW_W-1:0] from_yaw;
    logic signed [POS_W-1:0] to_x;
    logic signed [POS_W-1:0] to_y;

    modport source (output valid, output from_x, output from_y, output from_yaw,
                    output to_x, output to_y, input ready);
    modport sink   (input valid, input from_x, input from_y, input from_yaw,
                    input to_x, input to_y, output ready);
endinterface

interface hesc_out_if import hesc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] step_cost;
    logic              near_goal;

    modport source (output valid, output step_cost, output near_goal, input ready);
    modport sink   (input valid, input step_cost, input near_goal, output ready);
endinterface

>>> src/heading_error_step_cost_core.sv
// ---------------------------------------------------------------------------
// heading_error_step_cost_core
// Heading-error step cost: goal proximity test, pipelined CORDIC atan2,
// heading wrap and weighting.
// ---------------------------------------------------------------------------
// Path from input accept to output valid: stage registers a, b and c, one
// register per CORDIC cell, then the hesc_post pipeline registers.
// Throughput: one item per cycle while the output is not stalled; each CORDIC cell holds one item.
// Reset clears all stage valid bits and loads the register reset values.
module heading_error_step_cost_core import hesc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    hesc_in_if.sink               step_in,
    hesc_out_if.source            step_out
);

    logic signed [POS_W-1:0]  goal_x_reg;
    logic signed [POS_W-1:0]  goal_y_reg;
    logic [POS_W-1:0]         disable_reg;
    logic [WEIGHT_W-1:0]      weight_reg;
    logic [LIM_W-1:0]         lim_reg;

    logic                     a_valid_reg, b_valid_reg, c_valid_reg;
    logic                     rdy_a, rdy_b, rdy_c;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic signed [DIFF_W-1:0] efx_reg, efy_reg, etx_reg, ety_reg;
    logic signed [YAW_W-1:0]  yaw_a_reg, yaw_b_reg;
    logic [SQ_W-1:0]          sqfx_reg, sqfy_reg, sqtx_reg, sqty_reg;
    logic signed [CW-1:0]     xb_reg, yb_reg, xb_next, yb_next;
    logic signed [Z_W-1:0]    zb_reg, zb_next;
    logic                     zero_b_reg;
    logic signed [2*DIFF_W-1:0] pfx, pfy, ptx, pty;
    logic signed [CW-1:0]     xs, ys;
    logic [SUM_W-1:0]         sum_f, sum_t;
    hesc_side_t               side_c;

    logic                     cv   [0:CORDIC_STAGES];
    logic                     crdy [0:CORDIC_STAGES];
    logic signed [CW-1:0]     cx   [0:CORDIC_STAGES];
    logic signed [CW-1:0]     cy   [0:CORDIC_STAGES];
    logic signed [Z_W-1:0]    cz   [0:CORDIC_STAGES];
    hesc_side_t               cs   [0:CORDIC_STAGES];
    logic signed [CW-1:0]     xc_reg, yc_reg;
    logic signed [Z_W-1:0]    zc_reg;
    hesc_side_t               sc_reg;
    logic                     post_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg  <= '0;
            goal_y_reg  <= '0;
            disable_reg <= '0;
            weight_reg  <= WEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (hesc_reg_t'(cfg_index))
                REG_GOAL_X:  goal_x_reg  <= cfg_wdata[POS_W-1:0];
                REG_GOAL_Y:  goal_y_reg  <= cfg_wdata[POS_W-1:0];
                REG_DISABLE: disable_reg <= cfg_wdata[POS_W-1:0];
                REG_WEIGHT:  weight_reg  <= cfg_wdata[WEIGHT_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        lim_reg <= LIM_W'(disable_reg) * LIM_W'(disable_reg);
    end

    // ready chain, back to front
    always_comb
    begin
        crdy[CORDIC_STAGES] = post_rdy;
        for (int k = CORDIC_STAGES - 1; k >= 0; k--)
            crdy[k] = !cv[k+1] || crdy[k+1];
    end

    assign rdy_c         = !c_valid_reg || crdy[0];
    assign rdy_b         = !b_valid_reg || rdy_c;
    assign rdy_a         = !a_valid_reg || rdy_b;
    assign step_in.ready = rdy_a;

    always_comb
    begin
        pfx = efx_reg * efx_reg;
        pfy = efy_reg * efy_reg;
        ptx = etx_reg * etx_reg;
        pty = ety_reg * ety_reg;

        xs = {{(CW-DIFF_W-PRESCALE){dx_reg[DIFF_W-1]}}, dx_reg, {PRESCALE{1'b0}}};
        ys = {{(CW-DIFF_W-PRESCALE){dy_reg[DIFF_W-1]}}, dy_reg, {PRESCALE{1'b0}}};
        if (!dx_reg[DIFF_W-1])
        begin
            xb_next = xs;
            yb_next = ys;
            zb_next = '0;
        end
        else if (!dy_reg[DIFF_W-1])
        begin
            xb_next = ys;
            yb_next = -xs;
            zb_next = Z_W'(ANG_HALF_PI);
        end
        else
        begin
            xb_next = -ys;
            yb_next = xs;
            zb_next = -Z_W'(ANG_HALF_PI);
        end

        sum_f = SUM_W'(sqfx_reg) + SUM_W'(sqfy_reg);
        sum_t = SUM_W'(sqtx_reg) + SUM_W'(sqty_reg);
        side_c.yaw  = yaw_b_reg;
        side_c.zero = zero_b_reg;
        side_c.near = (sum_f <= SUM_W'(lim_reg)) || (sum_t <= SUM_W'(lim_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                a_valid_reg <= step_in.valid;
            if (rdy_b)
                b_valid_reg <= a_valid_reg;
            if (rdy_c)
                c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            dx_reg    <= DIFF_W'(step_in.to_x) - DIFF_W'(step_in.from_x);
            dy_reg    <= DIFF_W'(step_in.to_y) - DIFF_W'(step_in.from_y);
            efx_reg   <= DIFF_W'(step_in.from_x) - DIFF_W'(goal_x_reg);
            efy_reg   <= DIFF_W'(step_in.from_y) - DIFF_W'(goal_y_reg);
            etx_reg   <= DIFF_W'(step_in.to_x) - DIFF_W'(goal_x_reg);
            ety_reg   <= DIFF_W'(step_in.to_y) - DIFF_W'(goal_y_reg);
            yaw_a_reg <= step_in.from_yaw;
        end
        if (rdy_b)
        begin
            sqfx_reg   <= pfx[SQ_W-1:0];
            sqfy_reg   <= pfy[SQ_W-1:0];
            sqtx_reg   <= ptx[SQ_W-1:0];
            sqty_reg   <= pty[SQ_W-1:0];
            xb_reg     <= xb_next;
            yb_reg     <= yb_next;
            zb_reg     <= zb_next;
            zero_b_reg <= (dx_reg == '0) && (dy_reg == '0);
            yaw_b_reg  <= yaw_a_reg;
        end
        if (rdy_c)
        begin
            xc_reg <= xb_reg;
            yc_reg <= yb_reg;
            zc_reg <= zb_reg;
            sc_reg <= side_c;
        end
    end

    assign cv[0] = c_valid_reg;
    assign cx[0] = xc_reg;
    assign cy[0] = yc_reg;
    assign cz[0] = zc_reg;
    assign cs[0] = sc_reg;

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cell
        hesc_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (crdy[k]),
            .stage_idx (IDX_W'(k)),
            .in_valid  (cv[k]),
            .x_in      (cx[k]),
            .y_in      (cy[k]),
            .z_in      (cz[k]),
            .side_in   (cs[k]),
            .out_valid (cv[k+1]),
            .x_out     (cx[k+1]),
            .y_out     (cy[k+1]),
            .z_out     (cz[k+1]),
            .side_out  (cs[k+1])
        );
    end

    hesc_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cv[CORDIC_STAGES]),
        .in_ready  (post_rdy),
        .dir_z     (cz[CORDIC_STAGES]),
        .side_in   (cs[CORDIC_STAGES]),
        .weight    (weight_reg),
        .out_valid (step_out.valid),
        .out_ready (step_out.ready),
        .step_cost (step_out.step_cost),
        .near_goal (step_out.near_goal)
    );

endmodule

>>> src/hesc_cordic_cell.sv
// ---------------------------------------------------------------------------
// hesc_cordic_cell
// One vectoring CORDIC iteration with its own pipeline register.
// ---------------------------------------------------------------------------
module hesc_cordic_cell import hesc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [IDX_W-1:0]      stage_idx,
    input  logic                  in_valid,
    input  logic signed [CW-1:0]  x_in,
    input  logic signed [CW-1:0]  y_in,
    input  logic signed [Z_W-1:0] z_in,
    input  hesc_side_t            side_in,
    output logic                  out_valid,
    output logic signed [CW-1:0]  x_out,
    output logic signed [CW-1:0]  y_out,
    output logic signed [Z_W-1:0] z_out,
    output hesc_side_t            side_out
);

    logic                  valid_reg;
    logic signed [CW-1:0]  x_reg, x_next;
    logic signed [CW-1:0]  y_reg, y_next;
    logic signed [Z_W-1:0] z_reg, z_next;
    hesc_side_t            side_reg;
    logic signed [CW-1:0]  x_sh, y_sh;
    logic signed [Z_W-1:0] ang;

    always_comb
    begin
        x_sh = x_in >>> stage_idx;
        y_sh = y_in >>> stage_idx;
        ang  = atan_q16(stage_idx);
        if (!y_in[CW-1])
        begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule

>>> src/hesc_post.sv
// ---------------------------------------------------------------------------
// hesc_post
// Heading error wrap, absolute value, weighting, near-goal zeroing and output register.
// ---------------------------------------------------------------------------
module hesc_post import hesc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [Z_W-1:0] dir_z,
    input  hesc_side_t            side_in,
    input  logic [WEIGHT_W-1:0]   weight,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COST_W-1:0]     step_cost,
    output logic                  near_goal
);

    localparam logic signed [D_W-1:0] TWO_PI_D  = D_W'(ANG_TWO_PI);
    localparam logic signed [D_W-1:0] FOUR_PI_D = D_W'(2 * ANG_TWO_PI);
    localparam logic signed [D_W-1:0] NEG_TWO_PI_D = -D_W'(ANG_TWO_PI);
    localparam logic [MOD_W-1:0]      PI_M      = MOD_W'(ANG_PI);
    localparam logic [MOD_W-1:0]      TWO_PI_M  = MOD_W'(ANG_TWO_PI);

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic                  r1, r2, r3, r4;
    logic signed [D_W-1:0] d_reg, d_next;
    logic [MOD_W-1:0]      mod_reg, mod_next;
    logic [ERR_W-1:0]      err_reg, err_next;
    logic [COST_W-1:0]     cost_reg, cost_next;
    logic                  n1_reg, n2_reg, n3_reg, n4_reg;
    logic signed [D_W-1:0] dir_d, md;
    logic [PROD_W-1:0]     prod;

    assign r4       = !v4_reg || out_ready;
    assign r3       = !v3_reg || r4;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        dir_d  = side_in.zero ? '0 : D_W'(dir_z);
        d_next = dir_d - D_W'(side_in.yaw);

        if (d_reg < NEG_TWO_PI_D)
            md = d_reg + FOUR_PI_D;
        else if (d_reg < 0)
            md = d_reg + TWO_PI_D;
        else if (d_reg >= TWO_PI_D)
            md = d_reg - TWO_PI_D;
        else
            md = d_reg;
        mod_next = md[MOD_W-1:0];

        if (mod_reg > PI_M)
            err_next = ERR_W'(TWO_PI_M - mod_reg);
        else
            err_next = mod_reg[ERR_W-1:0];

        prod      = PROD_W'(err_reg) * PROD_W'(weight);
        cost_next = n3_reg ? '0 : prod[WEIGHT_FRAC +: COST_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r1)
                v1_reg <= in_valid;
            if (r2)
                v2_reg <= v1_reg;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            d_reg  <= d_next;
            n1_reg <= side_in.near;
        end
        if (r2)
        begin
            mod_reg <= mod_next;
            n2_reg  <= n1_reg;
        end
        if (r3)
        begin
            err_reg <= err_next;
            n3_reg  <= n2_reg;
        end
        if (r4)
        begin
            cost_reg <= cost_next;
            n4_reg   <= n3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign step_cost = cost_reg;
    assign near_goal = n4_reg;

`ifndef ASSERT_OFF
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> mod_reg < TWO_PI_M)
        else $error("wrapped heading error out of range");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> err_reg <= ERR_W'(ANG_PI))
        else $error("absolute heading error above pi");

    a_near_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && n4_reg) |-> cost_reg == '0)
        else $error("cost not zero near goal");
`endif

endmodule
